FILE: hdl/ffgtp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and controller/datapath handshake types for the tile packer.
package ffgtp_pkg;

  // Occupancy grid geometry.
  localparam int GRID_COLUMNS = 20;
  localparam int GRID_ROWS    = 8192;
  localparam int CELL_PIXELS  = 32;   // power of two: cell rounding is a shift

  localparam int CELL_SHIFT = $clog2(CELL_PIXELS);
  localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int FILL_W     = $clog2(GRID_ROWS + 1);
  localparam int RUN_W      = $clog2(GRID_ROWS + 1);
  localparam int COL_W      = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;

  // Field widths.
  localparam int ID_W     = 16;
  localparam int PIX_W    = 16;
  localparam int SIZE_W   = PIX_W - CELL_SHIFT + 1;
  localparam int POS_X_W  = 10;
  localparam int POS_Y_W  = 18;
  localparam int TILE_W_W = 10;
  localparam int TILE_H_W = 19;
  localparam int SHEET_W  = 19;
  localparam int BOTTOM_W = 20;

  // Sizing rules.
  localparam int QUARTER_MIN   = 128;
  localparam int QUARTER_SHIFT = 2;
  localparam int SHEET_MARGIN  = 64;

  // Fixed ten-column layout.
  localparam int FIXED_COLUMNS = 10;
  localparam int FIXED_TILE_W  = 64;
  localparam int FIXED_TILE_H  = 32;

  // Division of a 16-bit tile number by ten: (n * 52429) >> 19 is exact.
  localparam int DIV10_MULT   = 52429;
  localparam int DIV10_MULT_W = 17;
  localparam int DIV10_SHIFT  = 19;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LAYOUT_MODE,
    CFG_QUARTER_WIDE
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic mark_step;
    logic finish;
  } ffgtp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fixed_mode;
    logic zero_size;
    logic too_big;
    logic found;
    logic miss;
    logic mark_done;
    logic out_free;
  } ffgtp_sts_t;

endpackage

FILE: hdl/ffgtp_datapath.sv
`timescale 1ns / 1ps
// Datapath of the tile packer: configuration, occupancy grid, window search, marking and result word.
module ffgtp_datapath import ffgtp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  ffgtp_cmd_t             cmd,
  output ffgtp_sts_t             sts,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [ID_W-1:0]        tile_number,
  input  logic [PIX_W-1:0]       bitmap_width,
  input  logic [PIX_W-1:0]       bitmap_height,
  input  logic                   start_sheet,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   placed,
  output logic [ID_W-1:0]        tile_id,
  output logic [POS_X_W-1:0]     pos_x,
  output logic [POS_Y_W-1:0]     pos_y,
  output logic [TILE_W_W-1:0]    tile_w,
  output logic [TILE_H_W-1:0]    tile_h,
  output logic [SHEET_W-1:0]     sheet_height
);

  // Configuration and sheet state.
  logic                layout_mode;
  logic                quarter_wide;
  logic [FILL_W-1:0]   fill;        // rows below this were written since the sheet began
  logic [SHEET_W-1:0]  max_bottom;

  // Current tile.
  logic [ID_W-1:0]     id_q;
  logic [PIX_W-1:0]    w_q;
  logic [PIX_W-1:0]    h_q;
  logic [SIZE_W-1:0]   cols_q;
  logic [SIZE_W-1:0]   rows_q;
  logic [ID_W-1:0]     quot;

  // Scan state.
  logic [ROW_W-1:0]    rd_addr;
  logic                issued_all;
  logic                dv;
  logic [ROW_W-1:0]    drow;
  logic [RUN_W-1:0]    runs [GRID_COLUMNS];
  logic                found;
  logic                miss;
  logic [COL_W-1:0]    best_x;
  logic [ROW_W-1:0]    best_y;

  // Mark state.
  logic [SIZE_W-1:0]   m_issue;
  logic                wv;
  logic [ROW_W-1:0]    waddr;

  // Grid memory.
  logic [GRID_COLUMNS-1:0] grid_mem [GRID_ROWS];
  logic [GRID_COLUMNS-1:0] mem_q;

  // Load-time sizing.
  logic [PIX_W-1:0]              w_eff;
  logic [PIX_W:0]                w_round;
  logic [PIX_W:0]                h_round;
  logic [ID_W+DIV10_MULT_W-1:0]  prod;

  always_comb begin
    w_eff = bitmap_width;
    if (quarter_wide && (bitmap_width >= PIX_W'(QUARTER_MIN))) begin
      w_eff = bitmap_width >> QUARTER_SHIFT;
    end
    w_round = {1'b0, w_eff} + (PIX_W+1)'(CELL_PIXELS - 1);
    h_round = {1'b0, bitmap_height} + (PIX_W+1)'(CELL_PIXELS - 1);
    prod    = {{DIV10_MULT_W{1'b0}}, tile_number} * (ID_W+DIV10_MULT_W)'(DIV10_MULT);
  end

  // Row evaluation: per-column free-run counters and the leftmost complete window.
  logic [GRID_COLUMNS-1:0] row_bits;
  logic [GRID_COLUMNS-1:0] full_v;
  logic [GRID_COLUMNS-1:0] colmask;
  logic [GRID_COLUMNS-1:0] win_v;
  logic [RUN_W-1:0]        run_nxt [GRID_COLUMNS];
  logic [RUN_W-1:0]        rows_ext;
  logic                    any_win;
  logic [COL_W-1:0]        win_x;
  logic [RUN_W-1:0]        top_row;

  always_comb begin
    rows_ext = RUN_W'(rows_q);
    row_bits = (FILL_W'(drow) < fill) ? mem_q : '0;
    for (int c = 0; c < GRID_COLUMNS; c++) begin
      if (row_bits[c]) begin
        run_nxt[c] = '0;
      end else if (runs[c] >= rows_ext) begin
        run_nxt[c] = runs[c];
      end else begin
        run_nxt[c] = runs[c] + RUN_W'(1);
      end
      full_v[c]  = (run_nxt[c] >= rows_ext);
      colmask[c] = (cols_q > SIZE_W'(c));
    end
    any_win = 1'b0;
    win_x   = '0;
    for (int x = GRID_COLUMNS - 1; x >= 0; x--) begin
      win_v[x] = (((full_v >> x) & colmask) == colmask);
      if (win_v[x]) begin
        any_win = 1'b1;
        win_x   = COL_W'(x);
      end
    end
    top_row = RUN_W'(drow) + RUN_W'(1) - rows_ext;
  end

  // Memory port control.
  logic                    mark_issue;
  logic                    re;
  logic [ROW_W-1:0]        maddr;
  logic [ROW_W-1:0]        raddr;
  logic [GRID_COLUMNS-1:0] wmask;
  logic [GRID_COLUMNS-1:0] wdata;

  always_comb begin
    mark_issue = (m_issue < rows_q);
    maddr      = best_y + ROW_W'(m_issue);
    re         = (cmd.scan_step && !issued_all) || (cmd.mark_step && mark_issue);
    raddr      = cmd.mark_step ? maddr : rd_addr;
    wmask      = colmask << best_x;
    wdata      = ((FILL_W'(waddr) < fill) ? mem_q : '0) | wmask;
  end

  always_ff @(posedge clk) begin
    if (wv) begin
      grid_mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= grid_mem[raddr];
    end
  end

  // Result selection.
  logic                 res_placed;
  logic [POS_X_W-1:0]   res_px;
  logic [POS_Y_W-1:0]   res_py;
  logic [TILE_W_W-1:0]  res_tw;
  logic [TILE_H_W-1:0]  res_th;
  logic [ID_W-1:0]      rem_f;
  logic [BOTTOM_W-1:0]  bottom;
  logic [SHEET_W-1:0]   mb_next;
  logic [FILL_W-1:0]    new_end;
  logic                 zero_size;

  always_comb begin
    zero_size  = (cols_q == '0) || (rows_q == '0);
    rem_f      = id_q - ID_W'(quot * FIXED_COLUMNS);
    res_placed = 1'b0;
    res_px     = '0;
    res_py     = '0;
    res_tw     = '0;
    res_th     = '0;
    if (layout_mode) begin
      res_placed = 1'b1;
      res_px     = POS_X_W'(rem_f * FIXED_TILE_W);
      res_py     = POS_Y_W'(quot * FIXED_TILE_H);
      res_tw     = TILE_W_W'(FIXED_TILE_W);
      res_th     = TILE_H_W'(FIXED_TILE_H);
    end else if (zero_size) begin
      res_placed = 1'b1;
      res_tw     = TILE_W_W'(w_q);
      res_th     = TILE_H_W'(h_q);
    end else if (found) begin
      res_placed = 1'b1;
      res_px     = POS_X_W'(best_x * CELL_PIXELS);
      res_py     = POS_Y_W'(best_y * CELL_PIXELS);
      res_tw     = TILE_W_W'(w_q);
      res_th     = TILE_H_W'(h_q);
    end
    bottom  = BOTTOM_W'(res_py) + BOTTOM_W'(res_th);
    mb_next = (res_placed && (bottom > BOTTOM_W'(max_bottom))) ? SHEET_W'(bottom) : max_bottom;
    new_end = FILL_W'(best_y) + FILL_W'(rows_q);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode  <= 1'b0;
      quarter_wide <= 1'b0;
      fill         <= '0;
      max_bottom   <= '0;
      out_valid    <= 1'b0;
      issued_all   <= 1'b0;
      dv           <= 1'b0;
      found        <= 1'b0;
      miss         <= 1'b0;
      wv           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LAYOUT_MODE:  layout_mode  <= cfg_data[0];
          CFG_QUARTER_WIDE: quarter_wide <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        issued_all <= 1'b0;
        found      <= 1'b0;
        miss       <= 1'b0;
        if (start_sheet) begin
          fill       <= '0;
          max_bottom <= '0;
        end
      end

      if (cmd.scan_step && !issued_all) begin
        dv <= 1'b1;
        if (rd_addr == ROW_W'(GRID_ROWS - 1)) begin
          issued_all <= 1'b1;
        end
      end else begin
        dv <= 1'b0;
      end

      if (dv && !found) begin
        if (any_win) begin
          found <= 1'b1;
        end else if (drow == ROW_W'(GRID_ROWS - 1)) begin
          miss <= 1'b1;
        end
      end

      wv <= cmd.mark_step && mark_issue;

      if (cmd.finish) begin
        out_valid  <= 1'b1;
        max_bottom <= mb_next;
        if (!layout_mode && found && (new_end > fill)) begin
          fill <= new_end;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q    <= tile_number;
      w_q     <= w_eff;
      h_q     <= bitmap_height;
      cols_q  <= SIZE_W'(w_round >> CELL_SHIFT);
      rows_q  <= SIZE_W'(h_round >> CELL_SHIFT);
      quot    <= ID_W'(prod >> DIV10_SHIFT);
      rd_addr <= '0;
      m_issue <= '0;
      for (int c = 0; c < GRID_COLUMNS; c++) begin
        runs[c] <= '0;
      end
    end
    if (cmd.scan_step && !issued_all) begin
      drow <= rd_addr;
      if (rd_addr != ROW_W'(GRID_ROWS - 1)) begin
        rd_addr <= rd_addr + ROW_W'(1);
      end
    end
    if (dv && !found) begin
      for (int c = 0; c < GRID_COLUMNS; c++) begin
        runs[c] <= run_nxt[c];
      end
      if (any_win) begin
        best_x <= win_x;
        best_y <= ROW_W'(top_row);
      end
    end
    if (cmd.mark_step && mark_issue) begin
      m_issue <= m_issue + SIZE_W'(1);
      waddr   <= maddr;
    end
    if (cmd.finish) begin
      placed       <= res_placed;
      tile_id      <= id_q;
      pos_x        <= res_px;
      pos_y        <= res_py;
      tile_w       <= res_tw;
      tile_h       <= res_th;
      sheet_height <= SHEET_W'(mb_next + SHEET_MARGIN);
    end
  end

  // Status to the controller.
  always_comb begin
    sts.fixed_mode = layout_mode;
    sts.zero_size  = zero_size;
    sts.too_big    = (int'(cols_q) > GRID_COLUMNS) || (int'(rows_q) > GRID_ROWS);
    sts.found      = found;
    sts.miss       = miss;
    sts.mark_done  = !mark_issue && !wv;
    sts.out_free   = !out_valid || !out_stall;
  end

  // The grid is written only by the marking pass.
  a_write_in_mark: assert property (@(posedge clk) disable iff (rst)
    wv |-> $past(cmd.mark_step))
    else $error("grid write outside the marking pass");

  // A scan ends either with a window or with a miss, never both.
  a_found_or_miss: assert property (@(posedge clk) disable iff (rst)
    !(found && miss))
    else $error("scan reported both a window and a miss");

  // The written prefix never runs past the grid.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= GRID_ROWS)
    else $error("fill count beyond the grid");

  // A new result word is loaded only when the output register can take it.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result word overwritten while stalled");

endmodule

FILE: hdl/ffgtp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the tile packer: sequences load, scan, mark and result hand-off.
module ffgtp_ctrl import ffgtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  ffgtp_sts_t sts,
  output ffgtp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_MARK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_stall      = rst || (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.fixed_mode || sts.zero_size || sts.too_big) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          state_next = S_MARK;
        end else if (sts.miss) begin
          state_next = S_FINISH;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Marking starts only after the scan has produced a window.
  a_mark_after_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK && $past(state) == S_SCAN) |-> $past(sts.found))
    else $error("marking started without a window");

endmodule

FILE: hdl/first_fit_grid_tile_packer_core.sv
`timescale 1ns / 1ps
// Top level of the first-fit grid tile packer: controller and datapath joined by command and status.
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ---------------------------------------------
//   in        to core    in_valid / in_stall    tile_number, bitmap_width, bitmap_height,
//                                               start_sheet
//   out       from core  out_valid / out_stall  placed, tile_id, pos_x, pos_y, tile_w, tile_h,
//                                               sheet_height
//   cfg       to core    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A fixed-layout tile, a zero-size tile or one larger than the grid goes from accept to the
// result without a scan. A packed tile is scanned down to the bottom row of the window found
// and then marked over its height in cells, and a tile that fits nowhere is scanned through
// every grid row. The row scan and the marking pass each move one grid row per cycle through
// the single read port of the grid memory.
// Reset is synchronous and active high; it frees the whole grid at once through a fill count
// that marks which rows have been written, so no clearing pass is needed, and a start_sheet
// word clears the same way. The core takes one word at a time; a finished result waits in the
// output register while the next word is accepted. The input stalls and configuration is not
// ready while reset is high; otherwise configuration is always ready.
module first_fit_grid_tile_packer_core import ffgtp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ID_W-1:0]        tile_number,
  input  logic [PIX_W-1:0]       bitmap_width,
  input  logic [PIX_W-1:0]       bitmap_height,
  input  logic                   start_sheet,
  // Output channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   placed,
  output logic [ID_W-1:0]        tile_id,
  output logic [POS_X_W-1:0]     pos_x,
  output logic [POS_Y_W-1:0]     pos_y,
  output logic [TILE_W_W-1:0]    tile_w,
  output logic [TILE_H_W-1:0]    tile_h,
  output logic [SHEET_W-1:0]     sheet_height,
  // Configuration channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ffgtp_cmd_t cmd;
  ffgtp_sts_t sts;
  logic       cfg_we;

  // Register writes never wait, so the configuration port only holds off in reset.
  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  // The controller owns sequencing: it accepts a word only when idle and walks the datapath
  // through its scan and marking passes using the status flags returned.
  ffgtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the occupancy grid, the per-column free-run
  // counters used by the row scan, and the output register.
  ffgtp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .tile_number   (tile_number),
    .bitmap_width  (bitmap_width),
    .bitmap_height (bitmap_height),
    .start_sheet   (start_sheet),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .placed        (placed),
    .tile_id       (tile_id),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .tile_w        (tile_w),
    .tile_h        (tile_h),
    .sheet_height  (sheet_height)
  );

endmodule

FILE: sim/tb_first_fit_grid_tile_packer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit grid tile packer: directed table, then random sheets.
module tb_first_fit_grid_tile_packer_core;
  import ffgtp_pkg::*;

  // One result word as it leaves the output channel.
  typedef struct packed {
    logic                placed;
    logic [ID_W-1:0]     id;
    logic [POS_X_W-1:0]  x;
    logic [POS_Y_W-1:0]  y;
    logic [TILE_W_W-1:0] w;
    logic [TILE_H_W-1:0] h;
    logic [SHEET_W-1:0]  sheet;
  } placement_t;

  // One row of the directed table. The configuration wanted for the row rides along with the
  // tile, and a row either carries a hand-written result (typed) or defers to the predictor.
  typedef struct packed {
    logic              fixed_layout;
    logic              quarter;
    logic [ID_W-1:0]   number;
    logic [PIX_W-1:0]  width;
    logic [PIX_W-1:0]  height;
    logic              new_sheet;
    logic              typed;
    placement_t        want;
  } tile_row_t;

  localparam int DIRECTED_ROWS   = 23;
  localparam int RANDOM_PHASES   = 6;
  localparam int WORDS_PER_PHASE = 184;
  // A tile that fits nowhere costs a full grid scan, and a tall tile a scan and a marking pass
  // over its height in rows. The stimulus keeps both rare, so the whole run stays well inside
  // the limit.
  localparam int CYCLE_LIMIT     = 3_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ID_W-1:0]        tile_number = '0;
  logic [PIX_W-1:0]       bitmap_width = '0;
  logic [PIX_W-1:0]       bitmap_height = '0;
  logic                   start_sheet = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   placed;
  logic [ID_W-1:0]        tile_id;
  logic [POS_X_W-1:0]     pos_x;
  logic [POS_Y_W-1:0]     pos_y;
  logic [TILE_W_W-1:0]    tile_w;
  logic [TILE_H_W-1:0]    tile_h;
  logic [SHEET_W-1:0]     sheet_height;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  first_fit_grid_tile_packer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .tile_number  (tile_number),
    .bitmap_width (bitmap_width),
    .bitmap_height(bitmap_height),
    .start_sheet  (start_sheet),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .placed       (placed),
    .tile_id      (tile_id),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .tile_w       (tile_w),
    .tile_h       (tile_h),
    .sheet_height (sheet_height),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: our own copy of the occupancy grid, the deepest bottom edge placed on the
  // current sheet and the two configuration bits as last written through the config channel.
  logic [GRID_COLUMNS-1:0] sheet_cells [GRID_ROWS] = '{default: '0};
  int unsigned             deepest_bottom = 0;
  logic                    layout_fixed = 1'b0;
  logic                    quarter_on = 1'b0;

  // Placements predicted for accepted tiles, oldest first, still waiting on the output channel.
  placement_t placements_due [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  function automatic string show(placement_t p);
    return $sformatf("placed=%0d id=%0d x=%0d y=%0d w=%0d h=%0d sheet=%0d",
                     p.placed, p.id, p.x, p.y, p.w, p.h, p.sheet);
  endfunction

  // Only the first ten failures are spelled out; the rest just bump the count.
  function automatic void log_failure(string why);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d at cycle %0d: %s", mismatch_count, cycle_count, why);
  endfunction

  // Row-major first fit. For every column offset the scan walks down the grid and keeps the
  // topmost window; a later column only wins with a strictly smaller top row, so ties go to
  // the leftmost column. Once a window is known, rows below it cannot improve on it.
  function automatic logic first_free(int unsigned cols, int unsigned rows,
                                      output int unsigned fx, output int unsigned fy);
    int unsigned cx;
    int unsigned r;
    int unsigned run;
    logic [63:0] span;
    logic        hit;
    hit = 1'b0;
    fx = 0;
    fy = 0;
    if (cols > GRID_COLUMNS || rows > GRID_ROWS)
      return 1'b0;
    for (cx = 0; cx + cols <= GRID_COLUMNS; cx++) begin
      span = ((64'd1 << cols) - 64'd1) << cx;
      run = 0;
      for (r = 0; r < GRID_ROWS; r++) begin
        if (hit && r >= fy + rows)
          break;
        if ((sheet_cells[r] & span[GRID_COLUMNS-1:0]) != '0) begin
          run = 0;
        end else begin
          run++;
          if (run >= rows) begin
            if (!hit || r + 1 - rows < fy) begin
              hit = 1'b1;
              fy = r + 1 - rows;
              fx = cx;
            end
            break;
          end
        end
      end
    end
    return hit;
  endfunction

  // Works out the placement of one accepted tile and advances the predictor state.
  function automatic placement_t place_tile(logic [ID_W-1:0] number, logic [PIX_W-1:0] width,
                                            logic [PIX_W-1:0] height, logic new_sheet);
    placement_t  res;
    int unsigned w;
    int unsigned cols;
    int unsigned rows;
    int unsigned cx;
    int unsigned cy;
    int unsigned px;
    int unsigned py;
    int unsigned tw;
    int unsigned th;
    int unsigned r;
    logic        ok;
    logic [63:0] span;
    ok = 1'b0;
    cx = 0;
    cy = 0;
    px = 0;
    py = 0;
    tw = 0;
    th = 0;
    w = width;
    if (new_sheet) begin
      foreach (sheet_cells[k])
        sheet_cells[k] = '0;
      deepest_bottom = 0;
    end
    if (layout_fixed) begin
      // Ten 64-pixel columns, one 32-pixel row per ten tiles; the grid is not involved.
      ok = 1'b1;
      px = (32'(number) % FIXED_COLUMNS) * FIXED_TILE_W;
      py = (32'(number) / FIXED_COLUMNS) * FIXED_TILE_H;
      tw = FIXED_TILE_W;
      th = FIXED_TILE_H;
    end else begin
      if (quarter_on && w >= QUARTER_MIN)
        w = w / 4;
      cols = (w + CELL_PIXELS - 1) / CELL_PIXELS;
      rows = (32'(height) + CELL_PIXELS - 1) / CELL_PIXELS;
      // A tile with no extent in either direction lands at the origin without a search.
      if (cols == 0 || rows == 0)
        ok = 1'b1;
      else
        ok = first_free(cols, rows, cx, cy);
      if (ok) begin
        px = cx * CELL_PIXELS;
        py = cy * CELL_PIXELS;
        tw = w;
        th = height;
        if (cols != 0) begin
          span = ((64'd1 << cols) - 64'd1) << cx;
          for (r = 0; r < rows && cy + r < GRID_ROWS; r++)
            sheet_cells[cy + r] |= span[GRID_COLUMNS-1:0];
        end
      end
    end
    if (ok && py + th > deepest_bottom)
      deepest_bottom = py + th;
    res.placed = ok;
    res.id     = number;
    res.x      = POS_X_W'(px);
    res.y      = POS_Y_W'(py);
    res.w      = TILE_W_W'(tw);
    res.h      = TILE_H_W'(th);
    res.sheet  = SHEET_W'(deepest_bottom + SHEET_MARGIN);
    return res;
  endfunction

  // Offers one tile word, with an optional random gap in front of it, and records the expected
  // placement once the word is taken. Valid stays high on return so that back-to-back words
  // never see valid dropped and raised in the same time step.
  task automatic put_tile(logic [ID_W-1:0] number, logic [PIX_W-1:0] width,
                          logic [PIX_W-1:0] height, logic new_sheet,
                          logic typed, placement_t typed_want);
    placement_t predicted;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid      <= 1'b1;
    tile_number   <= number;
    bitmap_width  <= width;
    bitmap_height <= height;
    start_sheet   <= new_sheet;
    do @(posedge clk); while (in_stall);
    predicted = place_tile(number, width, height, new_sheet);
    if (typed)
      predicted = typed_want;
    placements_due = {placements_due, predicted};
  endtask

  // Stops offering words and waits until every outstanding placement has come back, then lets
  // the core sit for the given tail so that it is certainly idle.
  task automatic settle(int tail);
    in_valid <= 1'b0;
    while (placements_due.size() != 0)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Writes both registers back to back; the predictor copy changes at each handshake.
  task automatic set_config(logic fixed_layout, logic quarter);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LAYOUT_MODE;
    cfg_data  <= fixed_layout;
    do @(posedge clk); while (!cfg_ready);
    layout_fixed = fixed_layout;
    cfg_index <= CFG_QUARTER_WIDE;
    cfg_data  <= quarter;
    do @(posedge clk); while (!cfg_ready);
    quarter_on = quarter;
    cfg_valid <= 1'b0;
  endtask

  // Output side: stall at random and check each word that is taken against the oldest
  // expectation. Sampling at the clock edge sees the values from before the edge.
  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    string      bad;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{placed, tile_id, pos_x, pos_y, tile_w, tile_h, sheet_height};
        if (placements_due.size() == 0) begin
          log_failure({"result with nothing outstanding: ", show(got)});
        end else begin
          want = placements_due.pop_front();
          bad = "";
          if (got.placed !== want.placed) bad = {bad, " placed"};
          if (got.id !== want.id)         bad = {bad, " tile_id"};
          if (got.x !== want.x)           bad = {bad, " pos_x"};
          if (got.y !== want.y)           bad = {bad, " pos_y"};
          if (got.w !== want.w)           bad = {bad, " tile_w"};
          if (got.h !== want.h)           bad = {bad, " tile_h"};
          if (got.sheet !== want.sheet)   bad = {bad, " sheet_height"};
          if (bad != "")
            log_failure($sformatf("wrong%s\n  expected %s\n  actual   %s",
                                  bad, show(want), show(got)));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    tile_row_t        plan [DIRECTED_ROWS];
    logic [ID_W-1:0]  r_num;
    logic [PIX_W-1:0] r_w;
    logic [PIX_W-1:0] r_h;
    logic             r_new;
    int               pick;

    // The table walks packed mode first, then quartering, then the fixed layout. Rows with a
    // hand-written result are the ones that follow directly from the sizing rules.
    plan = '{
      // A single cell on a fresh sheet lands at the origin.
      '{1'b0, 1'b0, 16'd0, 16'd32, 16'd32, 1'b1, 1'b1,
        '{1'b1, 16'd0, 10'd0, 18'd0, 10'd32, 19'd32, 19'd96}},
      // A full-width strip cannot share row zero, so it drops to the next row.
      '{1'b0, 1'b0, 16'd1, 16'd640, 16'd1, 1'b0, 1'b1,
        '{1'b1, 16'd1, 10'd0, 18'd32, 10'd640, 19'd1, 19'd97}},
      // One pixel wider than the sheet never fits.
      '{1'b0, 1'b0, 16'd2, 16'd641, 16'd32, 1'b0, 1'b1,
        '{1'b0, 16'd2, 10'd0, 18'd0, 10'd0, 19'd0, 19'd97}},
      // Zero width: placed at the origin, marks nothing, still deepens the sheet.
      '{1'b0, 1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0, 1'b1,
        '{1'b1, 16'hFFFF, 10'd0, 18'd0, 10'd0, 19'd65535, 19'd65599}},
      // Zero height with the widest bitmap: placed, width wraps to the field width.
      '{1'b0, 1'b0, 16'd3, 16'hFFFF, 16'd0, 1'b0, 1'b1,
        '{1'b1, 16'd3, 10'd0, 18'd0, 10'd1023, 19'd0, 19'd65599}},
      '{1'b0, 1'b0, 16'd4, 16'd1, 16'd1, 1'b0, 1'b0, '0},
      // Largest bitmap in both directions is far too wide.
      '{1'b0, 1'b0, 16'd5, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1,
        '{1'b0, 16'd5, 10'd0, 18'd0, 10'd0, 19'd0, 19'd65599}},
      // A new sheet forgets the grid and the depth.
      '{1'b0, 1'b0, 16'd6, 16'd100, 16'd50, 1'b1, 1'b1,
        '{1'b1, 16'd6, 10'd0, 18'd0, 10'd100, 19'd50, 19'd114}},
      // Four full-width tiles of the tallest height fill every grid row.
      '{1'b0, 1'b0, 16'd20, 16'd640, 16'hFFFF, 1'b1, 1'b0, '0},
      '{1'b0, 1'b0, 16'd21, 16'd640, 16'hFFFF, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 16'd22, 16'd640, 16'hFFFF, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 16'd23, 16'd640, 16'hFFFF, 1'b0, 1'b0, '0},
      // Full grid: even one cell finds no window, and the depth stays at its maximum.
      '{1'b0, 1'b0, 16'd24, 16'd1, 16'd1, 1'b0, 1'b1,
        '{1'b0, 16'd24, 10'd0, 18'd0, 10'd0, 19'd0, 19'd262207}},
      '{1'b0, 1'b0, 16'd25, 16'd1, 16'd1, 1'b1, 1'b1,
        '{1'b1, 16'd25, 10'd0, 18'd0, 10'd1, 19'd1, 19'd65}},
      // Quartering: just below and at the threshold, the widest that still fits, one past it,
      // and the largest width.
      '{1'b0, 1'b1, 16'd7, 16'd127, 16'd32, 1'b0, 1'b0, '0},
      '{1'b0, 1'b1, 16'd8, 16'd128, 16'd32, 1'b0, 1'b0, '0},
      '{1'b0, 1'b1, 16'd9, 16'd2560, 16'd32, 1'b0, 1'b0, '0},
      '{1'b0, 1'b1, 16'd10, 16'd2564, 16'd1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b1, 16'd11, 16'hFFFF, 16'd32, 1'b0, 1'b0, '0},
      // Fixed layout ignores the bitmap size entirely.
      '{1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1,
        '{1'b1, 16'd0, 10'd0, 18'd0, 10'd64, 19'd32, 19'd96}},
      '{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1,
        '{1'b1, 16'hFFFF, 10'd320, 18'd209696, 10'd64, 19'd32, 19'd209792}},
      '{1'b1, 1'b0, 16'd9, 16'd7, 16'd7, 1'b0, 1'b0, '0},
      // Quartering has no effect in the fixed layout.
      '{1'b1, 1'b1, 16'd10, 16'd1000, 16'd3, 1'b1, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part runs with the sender gapping lightly and the receiver stalling hard.
    gap_pct   = 15;
    stall_pct = 56;
    foreach (plan[i]) begin
      if (plan[i].fixed_layout != layout_fixed || plan[i].quarter != quarter_on) begin
        settle(8);
        set_config(plan[i].fixed_layout, plan[i].quarter);
      end
      put_tile(plan[i].number, plan[i].width, plan[i].height, plan[i].new_sheet,
               plan[i].typed, plan[i].want);
    end

    // Random part. Each phase picks a configuration; the idling pattern changes every two
    // phases: light gaps and heavy stalls, then the reverse, then full throughput.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle(8);
      set_config(phase == 2 || phase == 5, phase % 2 == 1);
      case (phase / 2)
        0: begin
          gap_pct   = 15;
          stall_pct = 56;
        end
        1: begin
          gap_pct   = 56;
          stall_pct = 15;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        r_num = ID_W'($urandom());
        // Each phase opens a sheet; after that a new sheet starts now and then, which keeps
        // the filled part of the grid shallow and the row scans short.
        r_new = (n == 0) || ($urandom_range(11) == 0);
        // Widths mostly fit the sheet; some only fit when quartered, a few are zero or wild.
        pick = $urandom_range(99);
        if (pick < 55)
          r_w = PIX_W'($urandom_range(1, 320));
        else if (pick < 70)
          r_w = PIX_W'($urandom_range(321, 640));
        else if (pick < 78)
          r_w = PIX_W'(CELL_PIXELS * $urandom_range(1, GRID_COLUMNS));
        else if (pick < 88)
          r_w = PIX_W'($urandom_range(641, 2563));
        else if (pick < 91)
          r_w = '0;
        else
          r_w = PIX_W'($urandom());
        // Heights are mostly a few cells; tall tiles are rare since each row they cover costs both a
        // scan step and a marking step.
        pick = $urandom_range(99);
        if (pick < 80)
          r_h = PIX_W'($urandom_range(1, 160));
        else if (pick < 83)
          r_h = '0;
        else if (pick < 95)
          r_h = PIX_W'($urandom_range(161, 2048));
        else if (pick < 99)
          r_h = PIX_W'($urandom_range(2049, 16384));
        else
          r_h = PIX_W'($urandom());
        put_tile(r_num, r_w, r_h, r_new, 1'b0, '0);
      end
    end

    settle(32);
    if (mismatch_count == 0 && placements_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
